// ===== rtl/core/sbcs_pkg.sv =====
// Shared types and constants for the swept box collide-and-slide block.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package sbcs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int POS_W  = 32;
  localparam int VEL_W  = 22;
  localparam int BLK_W  = 16;
  localparam int BOX_W  = 20;
  localparam int SKIN_W = 16;
  localparam int CFG_W  = 20;
  localparam int OUT_W  = 23;
  // displacement accumulator: velocity sweep plus one push per listed block
  localparam int DISP_W = 25;
  // Minkowski bounds: block corner minus position minus box offset
  localparam int CW     = BLK_W + FRAC_BITS + 3;
  localparam int MA_W   = FRAC_BITS + 2;
  localparam int PROD_W = MA_W + VEL_W;
  localparam int DISP_LIM = 2097152;

  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5,
    CFG_SKIN  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BLK_W-1:0] x;
    logic [BLK_W-1:0] y;
    logic [BLK_W-1:0] z;
  } blk_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    blk_t             blk;
  } st_wr_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][VEL_W-1:0] vel;
    logic [CNT_W-1:0]      cnt;
    logic                  ovf;
  } job_t;

endpackage

// ===== rtl/core/sbcs_div.sv =====
// Restoring divider: quotient of (num << FRAC_BITS) / den for num < den.
// Depends on sbcs_pkg; one quotient bit per cycle.
module sbcs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sbcs_pkg::VEL_W-1:0] num,
  input  logic [sbcs_pkg::VEL_W-1:0] den,
  output logic                      done,
  output logic [sbcs_pkg::FRAC_BITS-1:0] quo
);

  localparam int SC_W = $clog2(sbcs_pkg::FRAC_BITS + 1);

  logic [sbcs_pkg::VEL_W-1:0]     rem_r;
  logic [sbcs_pkg::VEL_W-1:0]     den_r;
  logic [sbcs_pkg::FRAC_BITS-1:0] quo_r;
  logic [SC_W-1:0]                cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic [sbcs_pkg::VEL_W:0]       sh;
  logic                           ge;

  assign sh = {rem_r, 1'b0};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num;
        den_r <= den;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? sbcs_pkg::VEL_W'(sh - {1'b0, den_r}) : sbcs_pkg::VEL_W'(sh);
        quo_r <= {quo_r[sbcs_pkg::FRAC_BITS-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SC_W'(sbcs_pkg::FRAC_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/sbcs_jobq.sv =====
// Two-entry queue of resolve jobs between the front and the back.
// Depends on sbcs_pkg for the job type.
module sbcs_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sbcs_pkg::job_t  push_job,
  input  logic            pop,
  output logic            empty,
  output sbcs_pkg::job_t  head
);

  sbcs_pkg::job_t ent_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && cnt_r != 2'd2) begin
        ent_r[wp_r] <= push_job;
        wp_r        <= ~wp_r;
      end
      if (pop && cnt_r != 2'd0) rp_r <= ~rp_r;
      case ({push && cnt_r != 2'd2, pop && cnt_r != 2'd0})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

endmodule

// ===== rtl/core/sbcs_front.sv =====
// Front end: takes call items, appends blocks to the store, builds the job.
// Depends on sbcs_pkg; drives the block store write port and the job queue.
module sbcs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [sbcs_pkg::POS_W-1:0]       pos_x,
  input  logic [sbcs_pkg::POS_W-1:0]       pos_y,
  input  logic [sbcs_pkg::POS_W-1:0]       pos_z,
  input  logic [sbcs_pkg::VEL_W-1:0]       vel_x,
  input  logic [sbcs_pkg::VEL_W-1:0]       vel_y,
  input  logic [sbcs_pkg::VEL_W-1:0]       vel_z,
  input  logic [sbcs_pkg::BLK_W-1:0]       block_x,
  input  logic [sbcs_pkg::BLK_W-1:0]       block_y,
  input  logic [sbcs_pkg::BLK_W-1:0]       block_z,
  input  logic                             block_valid,
  input  logic                             last_block,
  output sbcs_pkg::st_wr_t                 st_wr,
  output logic                             job_push,
  output sbcs_pkg::job_t                   job
);

  logic                             open_r;
  logic [2:0][sbcs_pkg::POS_W-1:0]  pos_r;
  logic [2:0][sbcs_pkg::VEL_W-1:0]  vel_r;
  logic [sbcs_pkg::CNT_W-1:0]       cnt_r;
  logic                             ovf_r;
  logic                             room;
  logic [sbcs_pkg::CNT_W-1:0]       cnt_nxt;
  logic                             ovf_nxt;

  assign room    = cnt_r < sbcs_pkg::CNT_W'(sbcs_pkg::MAX_BLOCKS);
  assign cnt_nxt = (block_valid && room) ? cnt_r + 1'b1 : cnt_r;
  assign ovf_nxt = ovf_r | (block_valid & ~room);

  always_comb begin
    st_wr.we    = accept & block_valid & room;
    st_wr.addr  = cnt_r[sbcs_pkg::IDX_W-1:0];
    st_wr.blk.x = block_x;
    st_wr.blk.y = block_y;
    st_wr.blk.z = block_z;
    job_push    = accept & last_block;
    // first item of a call supplies position and velocity directly
    job.pos     = open_r ? pos_r : {pos_z, pos_y, pos_x};
    job.vel     = open_r ? vel_r : {vel_z, vel_y, vel_x};
    job.cnt     = cnt_nxt;
    job.ovf     = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      if (!open_r) begin
        pos_r <= {pos_z, pos_y, pos_x};
        vel_r <= {vel_z, vel_y, vel_x};
      end
      if (last_block) begin
        open_r <= 1'b0;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end else begin
        open_r <= 1'b1;
        cnt_r  <= cnt_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/sbcs_back.sv =====
// Back end: block store, sweep scan, hit selection, move and slide sequencer.
// Depends on sbcs_pkg and sbcs_div; holds the configuration registers.
module sbcs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [sbcs_pkg::CFG_W-1:0]     cfg_wdata,
  input  sbcs_pkg::st_wr_t               st_wr,
  input  logic                           job_valid,
  input  sbcs_pkg::job_t                 job,
  output logic                           job_pop,
  output logic                           busy,
  output logic                           out_strobe,
  output logic [sbcs_pkg::OUT_W-1:0]     out_disp_x,
  output logic [sbcs_pkg::OUT_W-1:0]     out_disp_y,
  output logic [sbcs_pkg::OUT_W-1:0]     out_disp_z,
  output logic                           out_list_overflow
);

  localparam int F   = sbcs_pkg::FRAC_BITS;
  localparam int CW  = sbcs_pkg::CW;
  localparam int VW  = sbcs_pkg::VEL_W;
  localparam int DW  = sbcs_pkg::DISP_W;
  localparam int PW  = sbcs_pkg::PROD_W;
  localparam int IW  = sbcs_pkg::IDX_W;
  localparam int NW  = sbcs_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_BND, S_FACE, S_DIV, S_MUL, S_SPAN, S_NEXTAX,
    S_PICK, S_MV, S_MVA, S_SKIN, S_SL, S_SLA, S_FINAL, S_OUT
  } state_t;

  // configuration
  logic signed [sbcs_pkg::BOX_W-1:0] bmin_r [3];
  logic signed [sbcs_pkg::BOX_W-1:0] bmax_r [3];
  logic [sbcs_pkg::SKIN_W-1:0]       skin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        bmin_r[k] <= '0;
        bmax_r[k] <= '0;
      end
      skin_r <= sbcs_pkg::SKIN_W'(7);
    end else if (cfg_we) begin
      case (sbcs_pkg::cfg_idx_t'(cfg_index))
        sbcs_pkg::CFG_MIN_X: bmin_r[0] <= cfg_wdata;
        sbcs_pkg::CFG_MIN_Y: bmin_r[1] <= cfg_wdata;
        sbcs_pkg::CFG_MIN_Z: bmin_r[2] <= cfg_wdata;
        sbcs_pkg::CFG_MAX_X: bmax_r[0] <= cfg_wdata;
        sbcs_pkg::CFG_MAX_Y: bmax_r[1] <= cfg_wdata;
        sbcs_pkg::CFG_MAX_Z: bmax_r[2] <= cfg_wdata;
        sbcs_pkg::CFG_SKIN:  skin_r    <= cfg_wdata[sbcs_pkg::SKIN_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                      state_r;
  logic [NW-1:0]               i_r, cnt_r, live_cnt_r;
  logic [1:0]                  a_r, k_r, bax_r;
  logic                        ob_r, ok_r, hneg_r, hax_hit_r;
  logic [1:0]                  hax_r;
  logic                        found_r, bhit_r, bneg_r, ovf_r;
  logic [IW-1:0]               bi_r;
  logic [F-1:0]                q_r;
  logic [F:0]                  ct_r, best_r;
  logic signed [sbcs_pkg::POS_W-1:0] pos_r [3];
  logic signed [DW-1:0]        disp_r [3];
  logic signed [VW-1:0]        vel_r [3];
  logic signed [CW-1:0]        mn_r [3];
  logic signed [CW-1:0]        mx_r [3];
  logic signed [PW-1:0]        prod_r;
  logic [sbcs_pkg::MAX_BLOCKS-1:0] live_r;
  sbcs_pkg::blk_t              rd_r;
  logic [$bits(sbcs_pkg::blk_t)-1:0] mem [sbcs_pkg::MAX_BLOCKS];

  logic                        strobe_r;
  logic [sbcs_pkg::OUT_W-1:0]  odisp_r [3];
  logic                        oovf_r;

  always_ff @(posedge clk) begin
    if (st_wr.we) mem[st_wr.addr] <= st_wr.blk;
    rd_r <= mem[i_r[IW-1:0]];
  end

  // combinational helpers
  logic [1:0]            oth_c;
  logic signed [VW-1:0]  va_c;
  logic signed [CW-1:0]  num_c;
  logic [VW-1:0]         den_c;
  logic                  face_ok_c;
  logic                  div_done;
  logic [F-1:0]          div_quo;
  logic [F:0]            ma_c;
  logic signed [VW-1:0]  mb_c;
  logic signed [PW:0]    fl_c, cl_c;
  logic                  span_ok_c;
  logic signed [CW-1:0]  cur_c [3];
  logic signed [CW-1:0]  bq_c [3];
  logic signed [DW-1:0]  sat_c [3];

  always_comb begin
    case (a_r)
      2'd0:    oth_c = ob_r ? 2'd2 : 2'd1;
      2'd1:    oth_c = ob_r ? 2'd2 : 2'd0;
      default: oth_c = ob_r ? 2'd1 : 2'd0;
    endcase
    va_c  = vel_r[a_r];
    num_c = (va_c > 0) ? mn_r[a_r] : -mx_r[a_r];
    den_c = (va_c > 0) ? va_c : VW'(-va_c);
    face_ok_c = (va_c != 0) && !num_c[CW-1] && (num_c < $signed({1'b0, CW'(den_c)}));

    case (state_r)
      S_MUL:   begin ma_c = {1'b0, q_r};  mb_c = vel_r[oth_c]; end
      S_MV:    begin ma_c = best_r;       mb_c = vel_r[k_r];   end
      default: begin ma_c = (F+1)'(sbcs_pkg::ONE_Q) - best_r; mb_c = vel_r[k_r]; end
    endcase

    fl_c = (PW+1)'(prod_r) >>> F;
    cl_c = ((PW+1)'(prod_r) + (PW+1)'(sbcs_pkg::ONE_Q - 1)) >>> F;
    span_ok_c = !(fl_c < (PW+1)'(mn_r[oth_c])) && !(cl_c > (PW+1)'(mx_r[oth_c]));

    for (int k = 0; k < 3; k++) begin
      cur_c[k] = CW'(pos_r[k]) + CW'(disp_r[k]);
      sat_c[k] = (disp_r[k] > DW'(sbcs_pkg::DISP_LIM)) ? DW'(sbcs_pkg::DISP_LIM) :
                 (disp_r[k] < -DW'(sbcs_pkg::DISP_LIM)) ? -DW'(sbcs_pkg::DISP_LIM) :
                 disp_r[k];
    end
    bq_c[0] = CW'($signed(rd_r.x)) <<< F;
    bq_c[1] = CW'($signed(rd_r.y)) <<< F;
    bq_c[2] = CW'($signed(rd_r.z)) <<< F;
  end

  sbcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_FACE && face_ok_c),
    .num   (num_c[VW-1:0]),
    .den   (den_c),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign job_pop = (state_r == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      live_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            for (int k = 0; k < 3; k++) begin
              pos_r[k]  <= job.pos[k];
              vel_r[k]  <= job.vel[k];
              disp_r[k] <= '0;
            end
            cnt_r      <= job.cnt;
            live_cnt_r <= job.cnt;
            ovf_r      <= job.ovf;
            i_r        <= '0;
            found_r    <= 1'b0;
            state_r    <= (job.cnt == '0) ? S_FINAL : S_RD;
          end
        end
        S_RD: begin
          if (i_r == cnt_r) state_r <= S_PICK;
          else if (!live_r[i_r[IW-1:0]]) i_r <= i_r + 1'b1;
          else state_r <= S_BND;
        end
        S_BND: begin
          mn_r[0] <= bq_c[0] - cur_c[0] - CW'(bmax_r[0]);
          mn_r[1] <= bq_c[1] - cur_c[1] - CW'(bmax_r[1]);
          mn_r[2] <= bq_c[2] - cur_c[2] - CW'(bmax_r[2]);
          mx_r[0] <= bq_c[0] + CW'(sbcs_pkg::ONE_Q) - cur_c[0] - CW'(bmin_r[0]);
          mx_r[1] <= bq_c[1] + CW'(sbcs_pkg::ONE_Q) - cur_c[1] - CW'(bmin_r[1]);
          mx_r[2] <= bq_c[2] + CW'(sbcs_pkg::ONE_Q) - cur_c[2] - CW'(bmin_r[2]);
          ct_r      <= (F+1)'(sbcs_pkg::ONE_Q);
          hax_hit_r <= 1'b0;
          a_r       <= 2'd0;
          state_r   <= S_FACE;
        end
        S_FACE: state_r <= face_ok_c ? S_DIV : S_NEXTAX;
        S_DIV: begin
          if (div_done) begin
            q_r <= div_quo;
            if ({1'b0, div_quo} < ct_r) begin
              ob_r    <= 1'b0;
              ok_r    <= 1'b1;
              state_r <= S_MUL;
            end else begin
              state_r <= S_NEXTAX;
            end
          end
        end
        S_MUL: begin
          prod_r  <= PW'($signed({1'b0, ma_c}) * mb_c);
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          if (!ob_r) begin
            ok_r    <= ok_r & span_ok_c;
            ob_r    <= 1'b1;
            state_r <= S_MUL;
          end else begin
            if (ok_r && span_ok_c) begin
              ct_r      <= {1'b0, q_r};
              hax_r     <= a_r;
              hax_hit_r <= 1'b1;
              hneg_r    <= (va_c > 0);
            end
            state_r <= S_NEXTAX;
          end
        end
        S_NEXTAX: begin
          if (a_r == 2'd2) begin
            // earliest hit wins; the first listed block keeps ties
            if (!found_r || best_r > ct_r) begin
              best_r <= ct_r;
              bi_r   <= i_r[IW-1:0];
              bax_r  <= hax_r;
              bhit_r <= hax_hit_r;
              bneg_r <= hneg_r;
            end
            found_r <= 1'b1;
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end else begin
            a_r     <= a_r + 2'd1;
            state_r <= S_FACE;
          end
        end
        S_PICK: begin
          live_r[bi_r] <= 1'b0;
          live_cnt_r   <= live_cnt_r - 1'b1;
          k_r          <= 2'd0;
          state_r      <= S_MV;
        end
        S_MV, S_SL: begin
          prod_r  <= PW'($signed({1'b0, ma_c}) * mb_c);
          state_r <= (state_r == S_MV) ? S_MVA : S_SLA;
        end
        S_MVA: begin
          disp_r[k_r] <= disp_r[k_r] + DW'(prod_r >>> F);
          if (k_r == 2'd2) state_r <= S_SKIN;
          else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_MV;
          end
        end
        S_SKIN: begin
          if (bhit_r) begin
            disp_r[bax_r] <= bneg_r ? disp_r[bax_r] - DW'(skin_r)
                                    : disp_r[bax_r] + DW'(skin_r);
            k_r     <= 2'd0;
            state_r <= S_SL;
          end else begin
            // no hit: full move already taken, stop sliding
            for (int k = 0; k < 3; k++) vel_r[k] <= '0;
            state_r <= S_FINAL;
          end
        end
        S_SLA: begin
          vel_r[k_r] <= (k_r == bax_r) ? '0 : VW'(prod_r >>> F);
          if (k_r == 2'd2) begin
            if (live_cnt_r == '0) state_r <= S_FINAL;
            else begin
              i_r     <= '0;
              found_r <= 1'b0;
              state_r <= S_RD;
            end
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_SL;
          end
        end
        S_FINAL: begin
          for (int k = 0; k < 3; k++) disp_r[k] <= disp_r[k] + DW'(vel_r[k]);
          state_r <= S_OUT;
        end
        S_OUT: begin
          for (int k = 0; k < 3; k++) odisp_r[k] <= sat_c[k][sbcs_pkg::OUT_W-1:0];
          oovf_r   <= ovf_r;
          strobe_r <= 1'b1;
          live_r   <= '0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (st_wr.we) live_r[st_wr.addr] <= 1'b1;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_disp_x        = odisp_r[0];
  assign out_disp_y        = odisp_r[1];
  assign out_disp_z        = odisp_r[2];
  assign out_list_overflow = oovf_r;

endmodule

// ===== rtl/core/swept_box_collide_slide.sv =====
// Top level of the swept box collide-and-slide block.
// Depends on sbcs_pkg, sbcs_front, sbcs_jobq and sbcs_back.
//
// A call is a run of items closed by one with last_block set; the first item
// gives position and velocity, each item with block_valid adds a block (up to
// 64, the rest are dropped and flagged). Resolution then scans the store once
// per removed block; in each scan, a face that reaches the 16-step shared
// divider and passes the time test takes the two span products on the shared
// multiplier. Each hit adds a move and a slide (a closing move alone when no
// block is hit), plus the pop, the final step and the output; the one divider
// and one multiplier are shared by all faces. The result appears on out_strobe
// for exactly one cycle and cannot be held off; busy is high from the closing
// item until that cycle.
module swept_box_collide_slide (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sbcs_pkg::POS_W-1:0]      in_pos_x,
  input  logic [sbcs_pkg::POS_W-1:0]      in_pos_y,
  input  logic [sbcs_pkg::POS_W-1:0]      in_pos_z,
  input  logic [sbcs_pkg::VEL_W-1:0]      in_vel_x,
  input  logic [sbcs_pkg::VEL_W-1:0]      in_vel_y,
  input  logic [sbcs_pkg::VEL_W-1:0]      in_vel_z,
  input  logic [sbcs_pkg::BLK_W-1:0]      in_block_x,
  input  logic [sbcs_pkg::BLK_W-1:0]      in_block_y,
  input  logic [sbcs_pkg::BLK_W-1:0]      in_block_z,
  input  logic                            in_block_valid,
  input  logic                            in_last_block,
  output logic                            out_strobe,
  output logic [sbcs_pkg::OUT_W-1:0]      out_disp_x,
  output logic [sbcs_pkg::OUT_W-1:0]      out_disp_y,
  output logic [sbcs_pkg::OUT_W-1:0]      out_disp_z,
  output logic                            out_list_overflow,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [sbcs_pkg::CFG_W-1:0]      cfg_wdata
);

  logic              accept;
  logic              q_empty;
  logic              back_busy;
  logic              job_push;
  logic              job_pop;
  sbcs_pkg::job_t    job_in;
  sbcs_pkg::job_t    job_head;
  sbcs_pkg::st_wr_t  st_wr;

  assign busy   = !q_empty || back_busy;
  assign accept = start && !busy;

  sbcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pos_z       (in_pos_z),
    .vel_x       (in_vel_x),
    .vel_y       (in_vel_y),
    .vel_z       (in_vel_z),
    .block_x     (in_block_x),
    .block_y     (in_block_y),
    .block_z     (in_block_z),
    .block_valid (in_block_valid),
    .last_block  (in_last_block),
    .st_wr       (st_wr),
    .job_push    (job_push),
    .job         (job_in)
  );

  sbcs_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .empty    (q_empty),
    .head     (job_head)
  );

  sbcs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .st_wr             (st_wr),
    .job_valid         (!q_empty),
    .job               (job_head),
    .job_pop           (job_pop),
    .busy              (back_busy),
    .out_strobe        (out_strobe),
    .out_disp_x        (out_disp_x),
    .out_disp_y        (out_disp_y),
    .out_disp_z        (out_disp_z),
    .out_list_overflow (out_list_overflow)
  );

  // a closing transaction keeps the block busy until its result
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_block |=> busy)
    else $error("closing transaction did not raise busy");

  // a result only follows a busy cycle
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(back_busy))
    else $error("result strobe without resolve");

  // no block store write while resolving
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.we |-> !back_busy)
    else $error("block store written during resolve");

  // the queue pops only into an idle back end
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> back_busy)
    else $error("job popped but back end stayed idle");

endmodule
